/* sv/chunk_sector_allocator_macros.svh */
// Assertion macros for the chunk sector allocator.
`ifndef CHUNK_SECTOR_ALLOCATOR_MACROS_SVH
`define CHUNK_SECTOR_ALLOCATOR_MACROS_SVH

// Check a condition at every clock edge out of reset.
`define CSA_ASSERT_HOLDS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// Check a consequence in the cycle after an antecedent.
`define CSA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) else $error(msg);

`endif

/* sv/csa_pkg.sv */
// Shared types, constants and helper functions of the chunk sector allocator.
package csa_pkg;

    localparam int SECTOR_LIMIT = 4096;
    localparam int SLOT_DEPTH   = 1024;
    localparam int MAP_WORDS    = 512;

    localparam logic [1:0] OP_WRITE   = 2'd0;
    localparam logic [1:0] OP_LOOKUP  = 2'd1;
    localparam logic [1:0] OP_INSTALL = 2'd2;

    localparam logic [2:0] STAT_IN_PLACE  = 3'd0;
    localparam logic [2:0] STAT_RELOCATED = 3'd1;
    localparam logic [2:0] STAT_TOO_LARGE = 3'd2;
    localparam logic [2:0] STAT_NO_SPACE  = 3'd3;
    localparam logic [2:0] STAT_FOUND     = 3'd4;
    localparam logic [2:0] STAT_EMPTY     = 3'd5;
    localparam logic [2:0] STAT_INSTALLED = 3'd6;

    typedef logic [12:0] sec_t;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [4:0]  chunk_x;
        logic [4:0]  chunk_z;
        logic [19:0] byte_length;
        logic [11:0] install_start;
        logic [7:0]  install_count;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [11:0] start_sector;
        logic [7:0]  sector_count;
        logic [7:0]  appended_sectors;
    } out_item_t;

    typedef struct packed {
        logic        en;
        logic [9:0]  addr;
        logic [19:0] data;
    } slot_wr_t;

    typedef struct packed {
        logic       en;
        logic [8:0] addr;
        logic [7:0] data;
    } map_wr_t;

    typedef struct packed {
        logic       done;
        logic       grow;
        sec_t       base;
        logic [7:0] run;
    } scan_t;

    function automatic logic [7:0] range_mask(logic [8:0] w, sec_t lo, sec_t hi);
        logic [7:0] m;
        sec_t       s;
        for (int j = 0; j < 8; j++) begin
            s    = {1'b0, w, 3'(j)};
            m[j] = (s >= lo) && (s < hi);
        end
        return m;
    endfunction

    function automatic scan_t scan_word(logic [7:0] bits, logic [8:0] w, sec_t base,
                                        logic [7:0] run, logic [7:0] need, sec_t extent);
        scan_t r;
        sec_t  s;
        r.done = 1'b0;
        r.grow = 1'b0;
        r.base = base;
        r.run  = run;
        for (int j = 0; j < 8; j++) begin
            s = {1'b0, w, 3'(j)};
            if (!r.done) begin
                if (s >= extent) begin
                    r.done = 1'b1;
                    r.grow = 1'b1;
                end else if (bits[j] && (s != 13'd0)) begin
                    r.run = r.run + 8'd1;
                    if (r.run == need) begin
                        r.done = 1'b1;
                    end
                end else begin
                    r.base = s + 13'd1;
                    r.run  = 8'd0;
                end
            end
        end
        return r;
    endfunction

endpackage

/* sv/csa_slot_mem.sv */
// Slot table memory with a clearing sweep after reset.
module csa_slot_mem (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [9:0]        rd_addr,
    output logic [19:0]       rd_data,
    input  csa_pkg::slot_wr_t wr,
    output logic              init_done
);

    logic [19:0] mem [csa_pkg::SLOT_DEPTH];
    logic [10:0] clr_cnt_reg;
    logic [10:0] clr_cnt_next;
    logic        we;
    logic [9:0]  wa;
    logic [19:0] wd;

    assign init_done = clr_cnt_reg[10];

    always_comb begin
        clr_cnt_next = clr_cnt_reg;
        if (!init_done) begin
            clr_cnt_next = clr_cnt_reg + 11'd1;
            we = 1'b1;
            wa = clr_cnt_reg[9:0];
            wd = 20'd0;
        end else begin
            we = wr.en;
            wa = wr.addr;
            wd = wr.data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= 11'd0;
        end else begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/csa_map_mem.sv */
// Free-sector bitmap memory, eight sectors per word.
module csa_map_mem (
    input  logic             aclk,
    input  logic [8:0]       rd_addr,
    output logic [7:0]       rd_data,
    input  csa_pkg::map_wr_t wr
);

    logic [7:0] mem [csa_pkg::MAP_WORDS];

    always_ff @(posedge aclk) begin
        if (wr.en) begin
            mem[wr.addr] <= wr.data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

/* sv/chunk_sector_allocator.sv */
// Chunk sector allocator top level: sequencer over slot table and free-sector bitmap.
//
//  channel  direction  handshake            beat
//  s_       in         s_valid / s_ready    csa_pkg::in_item_t
//  m_       out        m_valid / m_ready    csa_pkg::out_item_t
//
//  One item at a time. Lookup, install of start zero, oversize and in-place writes go
//  straight from the lookup to the response; other installs and writes add one bitmap word
//  (8 sectors) per cycle for each run marked or freed, and the first-fit scan walks one
//  bitmap word per cycle up to the extent.
//  After reset the slot table is swept to zero with s_ready low.
//  A result waiting on m_ready holds the sequencer in its response state.
`include "chunk_sector_allocator_macros.svh"

module chunk_sector_allocator (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  csa_pkg::in_item_t  s_payload,
    output logic               m_valid,
    input  logic               m_ready,
    output csa_pkg::out_item_t m_payload
);

    typedef enum logic [7:0] {
        S_INIT   = 8'b00000001,
        S_IDLE   = 8'b00000010,
        S_LOOK   = 8'b00000100,
        S_RSTART = 8'b00001000,
        S_RANGE  = 8'b00010000,
        S_SCAN0  = 8'b00100000,
        S_SCAN   = 8'b01000000,
        S_RESP   = 8'b10000000
    } state_t;

    state_t               state_reg, state_next;
    logic [1:0]           op_reg, op_next;
    logic [9:0]           idx_reg, idx_next;
    logic [8:0]           need_reg, need_next;
    logic [11:0]          ist_reg, ist_next;
    logic [7:0]           icnt_reg, icnt_next;
    logic [19:0]          entry_reg, entry_next;
    csa_pkg::sec_t        ext_reg, ext_next;
    csa_pkg::sec_t        base_reg, base_next;
    logic [7:0]           run_reg, run_next;
    logic [8:0]           scan_w_reg, scan_w_next;
    csa_pkg::sec_t        set_lo_reg, set_lo_next, set_hi_reg, set_hi_next;
    csa_pkg::sec_t        clr_lo_reg, clr_lo_next, clr_hi_reg, clr_hi_next;
    logic [8:0]           rng_w_reg, rng_w_next, rng_last_reg, rng_last_next;
    logic                 then_scan_reg, then_scan_next;
    csa_pkg::out_item_t   res_reg, res_next;
    logic                 m_valid_reg, m_valid_next;
    csa_pkg::out_item_t   m_data_reg, m_data_next;

    logic [9:0]           slot_rd_addr;
    logic [19:0]          slot_rd_data;
    csa_pkg::slot_wr_t    slot_wr;
    logic                 slot_ready;
    logic [8:0]           map_rd_addr;
    logic [7:0]           map_rd_data;
    csa_pkg::map_wr_t     map_wr;

    logic [11:0]          old_start;
    logic [7:0]           old_cnt;
    csa_pkg::sec_t        old_end, old_hi, inst_end, span_lo, span_hi, span_top;
    logic                 set_ne, clr_ne;
    csa_pkg::scan_t       sr;
    logic                 scan_done, scan_grow;
    logic [13:0]          scan_end;
    logic [7:0]           new_byte;

    csa_slot_mem u_slot_mem (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .rd_addr   (slot_rd_addr),
        .rd_data   (slot_rd_data),
        .wr        (slot_wr),
        .init_done (slot_ready)
    );

    csa_map_mem u_map_mem (
        .aclk    (aclk),
        .rd_addr (map_rd_addr),
        .rd_data (map_rd_data),
        .wr      (map_wr)
    );

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_payload = m_data_reg;

    always_comb begin
        old_start = entry_reg[19:8];
        old_cnt   = entry_reg[7:0];
        old_end   = {1'b0, old_start} + {5'd0, old_cnt};
        old_hi    = (old_end < ext_reg) ? old_end : ext_reg;
        inst_end  = {1'b0, ist_reg} + {5'd0, icnt_reg};
        set_ne    = set_lo_reg < set_hi_reg;
        clr_ne    = clr_lo_reg < clr_hi_reg;
        sr        = csa_pkg::scan_word(map_rd_data, scan_w_reg, base_reg, run_reg,
                                       need_reg[7:0], ext_reg);
        scan_done = sr.done || (scan_w_reg == 9'(csa_pkg::MAP_WORDS - 1));
        scan_grow = sr.grow || !sr.done;
        scan_end  = {1'b0, sr.base} + {5'd0, need_reg};
        new_byte  = (map_rd_data | csa_pkg::range_mask(rng_w_reg, set_lo_reg, set_hi_reg))
                    & ~csa_pkg::range_mask(rng_w_reg, clr_lo_reg, clr_hi_reg);
        if (set_ne && clr_ne) begin
            span_lo = (set_lo_reg < clr_lo_reg) ? set_lo_reg : clr_lo_reg;
            span_hi = (set_hi_reg > clr_hi_reg) ? set_hi_reg : clr_hi_reg;
        end else if (set_ne) begin
            span_lo = set_lo_reg;
            span_hi = set_hi_reg;
        end else if (clr_ne) begin
            span_lo = clr_lo_reg;
            span_hi = clr_hi_reg;
        end else begin
            span_lo = 13'd0;
            span_hi = 13'd1;
        end
        span_top = span_hi - 13'd1;
    end

    always_comb begin
        state_next     = state_reg;
        op_next        = op_reg;
        idx_next       = idx_reg;
        need_next      = need_reg;
        ist_next       = ist_reg;
        icnt_next      = icnt_reg;
        entry_next     = entry_reg;
        ext_next       = ext_reg;
        base_next      = base_reg;
        run_next       = run_reg;
        scan_w_next    = scan_w_reg;
        set_lo_next    = set_lo_reg;
        set_hi_next    = set_hi_reg;
        clr_lo_next    = clr_lo_reg;
        clr_hi_next    = clr_hi_reg;
        rng_w_next     = rng_w_reg;
        rng_last_next  = rng_last_reg;
        then_scan_next = then_scan_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_data_next    = m_data_reg;
        slot_rd_addr   = idx_reg;
        slot_wr        = '0;
        map_rd_addr    = 9'd0;
        map_wr         = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_INIT: begin
                if (slot_ready) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                slot_rd_addr = {s_payload.chunk_z, s_payload.chunk_x};
                if (s_valid) begin
                    op_next    = s_payload.opcode;
                    idx_next   = {s_payload.chunk_z, s_payload.chunk_x};
                    need_next  = 9'((21'(s_payload.byte_length) + 21'd4) >> 12) + 9'd1;
                    ist_next   = s_payload.install_start;
                    icnt_next  = s_payload.install_count;
                    state_next = S_LOOK;
                end
            end
            S_LOOK: begin
                entry_next = slot_rd_data;
                base_next  = 13'd0;
                run_next   = 8'd0;
                if (op_reg == csa_pkg::OP_WRITE) begin
                    if (need_reg > 9'd255) begin
                        res_next   = {csa_pkg::STAT_TOO_LARGE, slot_rd_data, 8'd0};
                        state_next = S_RESP;
                    end else if ((slot_rd_data[19:8] != 12'd0)
                                 && ({1'b0, slot_rd_data[7:0]} == need_reg)) begin
                        res_next   = {csa_pkg::STAT_IN_PLACE, slot_rd_data, 8'd0};
                        state_next = S_RESP;
                    end else if (slot_rd_data[19:8] != 12'd0) begin
                        set_lo_next    = {1'b0, slot_rd_data[19:8]};
                        set_hi_next    = ({1'b0, slot_rd_data[19:8]}
                                          + {5'd0, slot_rd_data[7:0]} < ext_reg)
                                         ? {1'b0, slot_rd_data[19:8]}
                                           + {5'd0, slot_rd_data[7:0]}
                                         : ext_reg;
                        clr_lo_next    = 13'd0;
                        clr_hi_next    = 13'd0;
                        then_scan_next = 1'b1;
                        state_next     = S_RSTART;
                    end else begin
                        state_next = S_SCAN0;
                    end
                end else if (op_reg == csa_pkg::OP_INSTALL) begin
                    if (ist_reg == 12'd0) begin
                        slot_wr    = {1'b1, idx_reg, 20'd0};
                        res_next   = {csa_pkg::STAT_INSTALLED, 20'd0, 8'd0};
                        state_next = S_RESP;
                    end else if (inst_end > 13'(csa_pkg::SECTOR_LIMIT)) begin
                        res_next   = {csa_pkg::STAT_NO_SPACE, slot_rd_data, 8'd0};
                        state_next = S_RESP;
                    end else begin
                        set_lo_next    = ext_reg;
                        set_hi_next    = (inst_end > ext_reg) ? inst_end : ext_reg;
                        ext_next       = (inst_end > ext_reg) ? inst_end : ext_reg;
                        clr_lo_next    = {1'b0, ist_reg};
                        clr_hi_next    = inst_end;
                        slot_wr        = {1'b1, idx_reg, ist_reg, icnt_reg};
                        res_next       = {csa_pkg::STAT_INSTALLED, ist_reg, icnt_reg, 8'd0};
                        then_scan_next = 1'b0;
                        state_next     = S_RSTART;
                    end
                end else begin
                    if (slot_rd_data[19:8] != 12'd0) begin
                        res_next = {csa_pkg::STAT_FOUND, slot_rd_data, 8'd0};
                    end else begin
                        res_next = {csa_pkg::STAT_EMPTY, 20'd0, 8'd0};
                    end
                    state_next = S_RESP;
                end
            end
            S_RSTART: begin
                map_rd_addr   = span_lo[11:3];
                rng_w_next    = span_lo[11:3];
                rng_last_next = span_top[11:3];
                state_next    = S_RANGE;
            end
            S_RANGE: begin
                map_wr = {1'b1, rng_w_reg, new_byte};
                if (rng_w_reg == rng_last_reg) begin
                    state_next = then_scan_reg ? S_SCAN0 : S_RESP;
                end else begin
                    rng_w_next  = rng_w_reg + 9'd1;
                    map_rd_addr = rng_w_reg + 9'd1;
                end
            end
            S_SCAN0: begin
                map_rd_addr = 9'd0;
                scan_w_next = 9'd0;
                state_next  = S_SCAN;
            end
            S_SCAN: begin
                map_rd_addr = scan_w_reg + 9'd1;
                if (!scan_done) begin
                    base_next   = sr.base;
                    run_next    = sr.run;
                    scan_w_next = scan_w_reg + 9'd1;
                end else if (scan_grow && (scan_end > 14'(csa_pkg::SECTOR_LIMIT))) begin
                    res_next = {csa_pkg::STAT_NO_SPACE, entry_reg, 8'd0};
                    if (old_start != 12'd0) begin
                        set_lo_next    = 13'd0;
                        set_hi_next    = 13'd0;
                        clr_lo_next    = {1'b0, old_start};
                        clr_hi_next    = old_hi;
                        then_scan_next = 1'b0;
                        state_next     = S_RSTART;
                    end else begin
                        state_next = S_RESP;
                    end
                end else begin
                    if (scan_grow) begin
                        ext_next = scan_end[12:0];
                        res_next = {csa_pkg::STAT_RELOCATED, sr.base[11:0], need_reg[7:0],
                                    need_reg[7:0] - sr.run};
                    end else begin
                        res_next = {csa_pkg::STAT_RELOCATED, sr.base[11:0], need_reg[7:0],
                                    8'd0};
                    end
                    set_lo_next    = 13'd0;
                    set_hi_next    = 13'd0;
                    clr_lo_next    = sr.base;
                    clr_hi_next    = scan_end[12:0];
                    slot_wr        = {1'b1, idx_reg, sr.base[11:0], need_reg[7:0]};
                    then_scan_next = 1'b0;
                    state_next     = S_RSTART;
                end
            end
            S_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_INIT;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            m_valid_reg <= 1'b0;
            ext_reg     <= 13'd1;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            ext_reg     <= ext_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg        <= op_next;
        idx_reg       <= idx_next;
        need_reg      <= need_next;
        ist_reg       <= ist_next;
        icnt_reg      <= icnt_next;
        entry_reg     <= entry_next;
        base_reg      <= base_next;
        run_reg       <= run_next;
        scan_w_reg    <= scan_w_next;
        set_lo_reg    <= set_lo_next;
        set_hi_reg    <= set_hi_next;
        clr_lo_reg    <= clr_lo_next;
        clr_hi_reg    <= clr_hi_next;
        rng_w_reg     <= rng_w_next;
        rng_last_reg  <= rng_last_next;
        then_scan_reg <= then_scan_next;
        res_reg       <= res_next;
        m_data_reg    <= m_data_next;
    end

    `CSA_ASSERT_NEXT(a_one_item, s_valid && s_ready, !s_ready, "second beat taken while busy")
    `CSA_ASSERT_HOLDS(a_extent_range, (ext_reg != 13'd0) && (ext_reg <= 13'(csa_pkg::SECTOR_LIMIT)), "extent out of range")
    `CSA_ASSERT_HOLDS(a_range_bound, (state_reg != S_RANGE) || (rng_w_reg <= rng_last_reg), "range word past last")

endmodule

/* bench/tb.sv */
// Testbench for chunk_sector_allocator: directed table then random beats, checked against a model.
`timescale 1ns / 1ps

module tb;

    localparam int SEC_CAP = 4096;
    localparam int RAND_BEATS = 1100;
    localparam longint CYCLE_LIMIT = 64'd4000000;
    localparam logic [1:0] OP_SPARE = 2'd3;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    csa_pkg::in_item_t s_payload = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    csa_pkg::out_item_t m_payload;

    always #6 aclk = ~aclk;

    chunk_sector_allocator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_payload(s_payload),
        .m_valid(m_valid), .m_ready(m_ready), .m_payload(m_payload)
    );

    // allocator state mirror
    logic [19:0]        slots [csa_pkg::SLOT_DEPTH];
    bit                 free_map [SEC_CAP];
    int                 extent;
    csa_pkg::out_item_t pending_results [$];
    int                 mismatches = 0;
    int                 failed = 0;
    longint             cycles = 0;
    bit                 stim_done = 0;

    typedef struct {
        csa_pkg::in_item_t  item;
        bit                 known;
        csa_pkg::out_item_t result;
    } row_t;

    function automatic void mark_sectors(int st, int ct, bit v);
        int s;
        for (int k = 0; k < ct; k++) begin
            s = st + k;
            if (s >= extent || s >= SEC_CAP) break;
            if (s != 0) free_map[s] = v;
        end
    endfunction

    function automatic csa_pkg::out_item_t allocate(csa_pkg::in_item_t it);
        csa_pkg::out_item_t r;
        int idx, need, os, oc, base, i, st, ct, app;
        bit grow;
        logic [19:0] ent;
        idx = int'({it.chunk_z, it.chunk_x});
        ent = slots[idx];
        r = '0;
        if (it.opcode == csa_pkg::OP_WRITE) begin
            need = (int'(it.byte_length) + 4) / 4096 + 1;
            os = int'(ent[19:8]);
            oc = int'(ent[7:0]);
            r.start_sector = ent[19:8];
            r.sector_count = ent[7:0];
            if (need > 255) begin
                r.status = csa_pkg::STAT_TOO_LARGE;
                return r;
            end
            if (os != 0 && oc == need) begin
                r.status = csa_pkg::STAT_IN_PLACE;
                return r;
            end
            if (os != 0) mark_sectors(os, oc, 1'b1);
            base = 0; i = 0; grow = 0; app = 0;
            while (i < need) begin
                if (base + i >= extent) begin
                    grow = 1;
                    break;
                end
                if (base + i < SEC_CAP && free_map[base + i]) i++;
                else begin
                    base += i + 1;
                    i = 0;
                end
            end
            if (grow) begin
                if (base + need > csa_pkg::SECTOR_LIMIT) begin
                    if (os != 0) mark_sectors(os, oc, 1'b0);
                    r.status = csa_pkg::STAT_NO_SPACE;
                    return r;
                end
                app = need - i;
                for (int s = extent; s < base + need && s < SEC_CAP; s++) free_map[s] = 1;
                extent = base + need;
            end
            mark_sectors(base, need, 1'b0);
            slots[idx] = {base[11:0], need[7:0]};
            r.status = csa_pkg::STAT_RELOCATED;
            r.start_sector = base[11:0];
            r.sector_count = need[7:0];
            r.appended_sectors = app[7:0];
            return r;
        end
        if (it.opcode == csa_pkg::OP_INSTALL) begin
            st = int'(it.install_start);
            ct = int'(it.install_count);
            if (st == 0) begin
                slots[idx] = '0;
                r.status = csa_pkg::STAT_INSTALLED;
                return r;
            end
            if (st + ct > csa_pkg::SECTOR_LIMIT) begin
                r.status = csa_pkg::STAT_NO_SPACE;
                r.start_sector = ent[19:8];
                r.sector_count = ent[7:0];
                return r;
            end
            if (st + ct > extent) begin
                for (int s = extent; s < st + ct && s < SEC_CAP; s++) free_map[s] = 1;
                extent = st + ct;
            end
            mark_sectors(st, ct, 1'b0);
            slots[idx] = {it.install_start, it.install_count};
            r.status = csa_pkg::STAT_INSTALLED;
            r.start_sector = it.install_start;
            r.sector_count = it.install_count;
            return r;
        end
        if (ent[19:8] != 0) begin
            r.status = csa_pkg::STAT_FOUND;
            r.start_sector = ent[19:8];
            r.sector_count = ent[7:0];
        end else begin
            r.status = csa_pkg::STAT_EMPTY;
        end
        return r;
    endfunction

    function automatic int short_gap();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
        if ($urandom_range(0, 2) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    function automatic csa_pkg::in_item_t mk(logic [1:0] op, int x, int z, int len, int st,
                                             int ct);
        csa_pkg::in_item_t it;
        it.opcode = op;
        it.chunk_x = x[4:0];
        it.chunk_z = z[4:0];
        it.byte_length = len[19:0];
        it.install_start = st[11:0];
        it.install_count = ct[7:0];
        return it;
    endfunction

    function automatic csa_pkg::in_item_t random_beat();
        csa_pkg::in_item_t it;
        logic [63:0] raw;
        int pick;
        raw = {$urandom, $urandom};
        it = raw[$bits(csa_pkg::in_item_t)-1:0];
        it.chunk_x = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(0, 3));
        it.chunk_z = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                                 : 5'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            it.opcode = csa_pkg::OP_WRITE;
            if ($urandom_range(0, 19) != 0) it.byte_length = 20'($urandom_range(0, 40000));
        end else if (pick < 75) begin
            it.opcode = csa_pkg::OP_LOOKUP;
        end else if (pick < 95) begin
            it.opcode = csa_pkg::OP_INSTALL;
            if ($urandom_range(0, 9) != 0) begin
                it.install_start = 12'($urandom_range(0, 400));
                it.install_count = 8'($urandom_range(0, 12));
            end
        end else begin
            it.opcode = OP_SPARE;
        end
        return it;
    endfunction

    task automatic send(csa_pkg::in_item_t it);
        int gap;
        gap = short_gap();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_payload <= it;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(allocate(it));
    endtask

    // ready side
    initial begin
        int gap;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 3) == 0) begin
                gap = short_gap();
                if (gap != 0) begin
                    m_ready <= 1'b0;
                    repeat (gap) @(negedge aclk);
                end
            end
            m_ready <= 1'b1;
        end
    end

    // result check
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10) $display("unexpected beat %p", m_payload);
            end else begin
                csa_pkg::out_item_t want;
                want = pending_results.pop_front();
                if (want !== m_payload) begin
                    failed = 1;
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch exp %p got %p", want, m_payload);
                end
            end
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin
        row_t rows [$];
        row_t rw;
        int waited;
        for (int k = 0; k < csa_pkg::SLOT_DEPTH; k++) slots[k] = '0;
        for (int k = 0; k < SEC_CAP; k++) free_map[k] = 0;
        extent = 1;

        rw.known = 1;
        rw.item = mk(csa_pkg::OP_LOOKUP, 0, 0, 0, 0, 0);
        rw.result = '{csa_pkg::STAT_EMPTY, 0, 0, 0};
        rows.push_back(rw);
        rw.item = mk(csa_pkg::OP_WRITE, 31, 31, 1048575, 0, 0);
        rw.result = '{csa_pkg::STAT_TOO_LARGE, 0, 0, 0};
        rows.push_back(rw);
        rw.item = mk(csa_pkg::OP_WRITE, 0, 0, 0, 0, 0);
        rw.result = '{csa_pkg::STAT_RELOCATED, 1, 1, 1};
        rows.push_back(rw);
        rw.item = mk(csa_pkg::OP_WRITE, 0, 0, 4091, 0, 0);
        rw.result = '{csa_pkg::STAT_IN_PLACE, 1, 1, 0};
        rows.push_back(rw);
        rw.item = mk(csa_pkg::OP_INSTALL, 5, 5, 0, 4095, 255);
        rw.result = '{csa_pkg::STAT_NO_SPACE, 0, 0, 0};
        rows.push_back(rw);
        rw.item = mk(csa_pkg::OP_INSTALL, 5, 5, 0, 0, 255);
        rw.result = '{csa_pkg::STAT_INSTALLED, 0, 0, 0};
        rows.push_back(rw);
        rw.known = 0;
        rows.push_back('{mk(csa_pkg::OP_WRITE, 0, 0, 4092, 0, 0), 0, '0});
        rows.push_back('{mk(csa_pkg::OP_WRITE, 1, 0, 1044475, 0, 0), 0, '0});
        rows.push_back('{mk(csa_pkg::OP_WRITE, 2, 0, 1044476, 0, 0), 0, '0});
        rows.push_back('{mk(csa_pkg::OP_INSTALL, 3, 0, 0, 3841, 255), 0, '0});
        rows.push_back('{mk(csa_pkg::OP_WRITE, 4, 0, 1040000, 0, 0), 0, '0});
        rows.push_back('{mk(csa_pkg::OP_WRITE, 1, 0, 100, 0, 0), 0, '0});
        rows.push_back('{mk(csa_pkg::OP_WRITE, 6, 0, 9000, 0, 0), 0, '0});
        rows.push_back('{mk(csa_pkg::OP_INSTALL, 0, 0, 0, 2, 3), 0, '0});
        rows.push_back('{mk(csa_pkg::OP_LOOKUP, 0, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(OP_SPARE, 1, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(csa_pkg::OP_INSTALL, 3, 0, 0, 0, 0), 0, '0});
        rows.push_back('{mk(csa_pkg::OP_WRITE, 7, 0, 0, 0, 0), 0, '0});

        repeat (3) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (rows[k]) begin
            send(rows[k].item);
            if (rows[k].known && pending_results[$] !== rows[k].result) begin
                failed = 1;
                mismatches++;
                if (mismatches <= 10)
                    $display("row %0d exp %p model %p", k, rows[k].result, pending_results[$]);
            end
        end
        for (int n = 0; n < RAND_BEATS; n++) send(random_beat());
        @(negedge aclk);
        s_valid <= 1'b0;

        waited = 0;
        while (pending_results.size() != 0) @(posedge aclk);
        while (waited < 200) begin
            @(posedge aclk);
            waited++;
        end
        if (failed == 0 && pending_results.size() == 0)
            $display("tb OK");
        else
            $display("tb NOT OK");
        $finish;
    end
endmodule
